// File: sv/assert_macros.svh
// Assertion macros shared by the transcoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

// File: sv/u16u8_pkg.sv
// Types and constants shared by the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

  // Configuration register indexes.
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth = 7;
  localparam logic [CfgIndexWidth-1:0] RegOutputCapacity = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegOutputEnable = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegTrimTrailingZeros = 2'd2;

  localparam int DefaultMaxCapacity = 64;
  localparam int DefaultQueueDepth = 4;
  localparam logic [6:0] CapacityReset = 7'd64;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_present;
    logic        end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       error_flag;
    logic [5:0] final_length;
  } out_word_t;

  // One classified item: its encoded bytes and, on an end item, the status.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            end_item;
    logic            error;
    logic [5:0]      length;
  } job_t;

endpackage

`default_nettype wire

// File: sv/u16u8_front.sv
// Front end: accepts code units, tracks surrogates and capacity, builds jobs.
`timescale 1ns / 1ps
`default_nettype none

module u16u8_front #(
  parameter int MAX_CAPACITY = u16u8_pkg::DefaultMaxCapacity
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire u16u8_pkg::in_word_t                  in_word,
  input  wire logic                                 cfg_write,
  input  wire logic [u16u8_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [u16u8_pkg::CfgDataWidth-1:0]   cfg_data,
  output logic                                      push,
  output u16u8_pkg::job_t                           job,
  input  wire logic                                 queue_full
);
  import u16u8_pkg::*;

  localparam int CapLimit = (MAX_CAPACITY < 64) ? MAX_CAPACITY : 64;

  logic [6:0] output_capacity;
  logic       output_enable;
  logic       trim_trailing_zeros;

  logic [9:0] pending_high, pending_high_next;
  logic       pending_valid, pending_valid_next;
  logic       error_seen, error_seen_next;
  logic       cap_hit, cap_hit_next;
  logic [6:0] bytes_written, bytes_written_next;
  logic [6:0] trimmed_length, trimmed_length_next;

  logic        accept;
  logic        is_high, is_low;
  logic        emit_req;
  logic [20:0] cp;
  logic [2:0]  size;
  logic [2:0]  count;
  logic [7:0]  sum;
  logic [6:0]  cap_eff;
  logic [6:0]  len_sel;
  logic [3:0][7:0] enc;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= CapacityReset;
      output_enable <= 1'b1;
      trim_trailing_zeros <= 1'b1;
    end else if (cfg_write) begin
      if (cfg_index == RegOutputCapacity) output_capacity <= cfg_data;
      if (cfg_index == RegOutputEnable) output_enable <= cfg_data[0];
      if (cfg_index == RegTrimTrailingZeros) trim_trailing_zeros <= cfg_data[0];
    end
  end

  assign cap_eff = (output_capacity > 7'(CapLimit)) ? 7'(CapLimit) : output_capacity;
  assign is_high = (in_word.code_unit[15:10] == 6'b110110);
  assign is_low = (in_word.code_unit[15:10] == 6'b110111);
  assign in_stall = queue_full;
  assign accept = in_valid && !queue_full;

  always_comb begin
    pending_high_next = pending_high;
    pending_valid_next = pending_valid;
    error_seen_next = error_seen;
    cap_hit_next = cap_hit;
    bytes_written_next = bytes_written;
    trimmed_length_next = trimmed_length;
    emit_req = 1'b0;
    cp = 21'(in_word.code_unit);
    if (in_word.unit_present && !error_seen) begin
      if (pending_valid) begin
        pending_valid_next = 1'b0;
        pending_high_next = '0;
        if (is_low) begin
          emit_req = 1'b1;
          cp = 21'h10000 + 21'({pending_high, in_word.code_unit[9:0]});
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (is_high) begin
        pending_high_next = in_word.code_unit[9:0];
        pending_valid_next = 1'b1;
      end else if (is_low) begin
        error_seen_next = 1'b1;
      end else begin
        emit_req = 1'b1;
      end
    end

    priority if (cp < 21'h80) size = 3'd1;
    else if (cp < 21'h800) size = 3'd2;
    else if (cp < 21'h10000) size = 3'd3;
    else size = 3'd4;

    sum = {1'b0, bytes_written} + 8'(size);
    count = 3'd0;
    if (emit_req && output_enable && !cap_hit) begin
      if (sum >= {1'b0, cap_eff}) begin
        cap_hit_next = 1'b1;
      end else begin
        count = size;
        bytes_written_next = sum[6:0];
        if (cp != 21'd0) trimmed_length_next = sum[6:0];
      end
    end
  end

  // Bytes are packed lead byte first in slot zero.
  always_comb begin
    enc = '0;
    unique case (size)
      3'd1: enc[0] = cp[7:0];
      3'd2: begin
        enc[0] = 8'hc0 | 8'(cp[10:6]);
        enc[1] = 8'h80 | 8'(cp[5:0]);
      end
      3'd3: begin
        enc[0] = 8'he0 | 8'(cp[15:12]);
        enc[1] = 8'h80 | 8'(cp[11:6]);
        enc[2] = 8'h80 | 8'(cp[5:0]);
      end
      default: begin
        enc[0] = 8'hf0 | 8'(cp[20:18]);
        enc[1] = 8'h80 | 8'(cp[17:12]);
        enc[2] = 8'h80 | 8'(cp[11:6]);
        enc[3] = 8'h80 | 8'(cp[5:0]);
      end
    endcase
  end

  assign len_sel = trim_trailing_zeros ? trimmed_length_next : bytes_written_next;

  always_comb begin
    job.bytes = enc;
    job.count = count;
    job.end_item = in_word.end_of_string;
    // A high surrogate still waiting at the end of the string is unpaired.
    job.error = error_seen_next || pending_valid_next;
    job.length = output_enable ? len_sel[5:0] : 6'd0;
  end

  assign push = accept && ((count != 3'd0) || in_word.end_of_string);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high <= '0;
      pending_valid <= 1'b0;
      error_seen <= 1'b0;
      cap_hit <= 1'b0;
      bytes_written <= '0;
      trimmed_length <= '0;
    end else if (accept) begin
      if (in_word.end_of_string) begin
        pending_high <= '0;
        pending_valid <= 1'b0;
        error_seen <= 1'b0;
        cap_hit <= 1'b0;
        bytes_written <= '0;
        trimmed_length <= '0;
      end else begin
        pending_high <= pending_high_next;
        pending_valid <= pending_valid_next;
        error_seen <= error_seen_next;
        cap_hit <= cap_hit_next;
        bytes_written <= bytes_written_next;
        trimmed_length <= trimmed_length_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/u16u8_queue.sv
// Short job queue between the front end and the byte serializer.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::DefaultQueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire u16u8_pkg::job_t push_job,
  output logic                 full,
  input  wire logic            pop,
  output u16u8_pkg::job_t      head,
  output logic                 not_empty
);
  import u16u8_pkg::*;

  localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CountWidth = $clog2(DEPTH + 1);

  job_t mem [DEPTH];
  logic [PtrWidth-1:0]   wr_ptr, rd_ptr;
  logic [CountWidth-1:0] fill;

  assign full = (fill == CountWidth'(DEPTH));
  assign not_empty = (fill != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  `ASSERT_CLK(a_fill_bound, clk, rst, fill <= CountWidth'(DEPTH), "queue fill above depth")
  `ASSERT_CLK(a_no_overflow, clk, rst, push |-> !full, "push into a full queue")
  `ASSERT_CLK(a_no_underflow, clk, rst, pop |-> not_empty, "pop from an empty queue")

endmodule

`default_nettype wire

// File: sv/u16u8_back.sv
// Back end: serializes queued jobs into one output word per cycle while out_stall is low.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module u16u8_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire u16u8_pkg::job_t   head,
  input  wire logic              not_empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output u16u8_pkg::out_word_t   out_word
);
  import u16u8_pkg::*;

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       load;
  logic       is_final;

  // A job with no bytes still yields one status-only word.
  assign last_idx = (head.count == 3'd0) ? 2'd0 : 2'(head.count - 3'd1);
  assign is_final = (idx == last_idx);
  assign load = not_empty && (!out_valid || !out_stall);
  assign pop = load && is_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= is_final ? 2'd0 : idx + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word.out_byte <= (head.count == 3'd0) ? 8'd0 : head.bytes[idx];
      out_word.byte_valid <= (head.count != 3'd0);
      out_word.last <= is_final;
      out_word.error_flag <= is_final && head.end_item && head.error;
      out_word.final_length <= (is_final && head.end_item) ? head.length : 6'd0;
    end
  end

  `ASSERT_CLK(a_err_on_last, clk, rst, out_valid && out_word.error_flag |-> out_word.last,
    "error flag on a word that is not last")
  `ASSERT_CLK(a_len_on_last, clk, rst,
    out_valid && (out_word.final_length != 6'd0) |-> out_word.last,
    "final length on a word that is not last")
  `ASSERT_CLK(a_job_held, clk, rst, (idx != 2'd0) |-> not_empty,
    "job left the queue before all its bytes were sent")

endmodule

`default_nettype wire

// File: sv/utf16le_to_utf8_transcoder_unit.sv
// An accepted code unit's job is written into the job queue, then registered into out_word.
// Throughput: one code unit per cycle while the job queue has room; an item yields one
// output word per byte (1 to 4), and an item with no bytes yields none unless it ends the string.
// Sustained rate is set by the byte-wide output serializer in the back end.
// Reset (rst, synchronous): clears string state and queue, restores register
// defaults (capacity 64, output on, trimming on); no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module utf16le_to_utf8_transcoder_unit #(
  parameter int MAX_CAPACITY = u16u8_pkg::DefaultMaxCapacity,
  parameter int QUEUE_DEPTH = u16u8_pkg::DefaultQueueDepth
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire u16u8_pkg::in_word_t                  in_word,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output u16u8_pkg::out_word_t                      out_word,
  input  wire logic                                 cfg_write,
  input  wire logic [u16u8_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [u16u8_pkg::CfgDataWidth-1:0]   cfg_data
);
  import u16u8_pkg::*;

  logic push, pop, queue_full, not_empty;
  job_t push_job, head;

  u16u8_front #(.MAX_CAPACITY(MAX_CAPACITY)) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .job(push_job),
    .queue_full(queue_full)
  );

  u16u8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .full(queue_full),
    .pop(pop),
    .head(head),
    .not_empty(not_empty)
  );

  u16u8_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .not_empty(not_empty),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

endmodule

`default_nettype wire
